// ----- rtl/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants
// Widths, transaction structs and the wavefront record that moves down the
// cell chain of the longest gapped subsequence block.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int MAX_ITEMS   = 1024;
   localparam int HEIGHT_BITS = 48;
   localparam int GAP_BITS    = 48;
   localparam int LEN_BITS    = $clog2(MAX_ITEMS + 1);
   localparam int IDX_BITS    = $clog2(MAX_ITEMS);
   localparam int CMP_BITS    = (HEIGHT_BITS > GAP_BITS) ? HEIGHT_BITS : GAP_BITS;

   typedef struct packed {
      logic                   start_req;
      logic [HEIGHT_BITS-1:0] height;
   } req_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] chain_length;
      logic [LEN_BITS-1:0] predecessor;
      logic [LEN_BITS-1:0] best_length;
      logic [LEN_BITS-1:0] best_end;
      logic                full_res;
   } rsp_type;

   // One item on its way through the cells: its slot and the best
   // candidate found so far among the cells already passed.
   typedef struct packed {
      logic                   start;
      logic                   full;
      logic [LEN_BITS-1:0]    count;
      logic [HEIGHT_BITS-1:0] height;
      logic [LEN_BITS-1:0]    cand_len;
      logic [LEN_BITS-1:0]    cand_idx;
   } wave_type;

endpackage

// ----- rtl/longest_gapped_subsequence_top.sv -----
// ----------------------------------------------------------------------------
// longest_gapped_subsequence_top: streaming longest gapped subsequence
// Each height is stored in a row of cells; it finds the longest earlier
// chain whose height differs by at least min_gap.
// ----------------------------------------------------------------------------
// Every item travels down a chain of MAX_ITEMS cells, one cell per cycle,
// and then into one output register. The accepting edge already loads the
// first cell. Items follow one another cycle by cycle: an item is stored in
// its cell before the next item passes that cell, so one item per cycle is
// sustained while the result channel does not stall. A stall on the result
// channel freezes the whole chain and drops req_ready. Both ready outputs
// stay low during reset. min_gap is taken at face value while items are in
// flight, so write it only when the block is idle. After the store is full,
// items are still answered but not stored, until an item with start_req set.
module longest_gapped_subsequence_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lgs_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lgs_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lgs_pkg::GAP_BITS-1:0] csr_data
);
   import lgs_pkg::*;

   logic [LEN_BITS-1:0] item_count_ff;
   logic [LEN_BITS-1:0] item_count_in;
   logic [GAP_BITS-1:0] min_gap_ff;
   logic                advance;
   logic                accept;
   logic [LEN_BITS-1:0] slot;
   logic                full;
   wave_type            head_wave;
   logic                stage_valid [0:MAX_ITEMS];
   wave_type            stage_wave  [0:MAX_ITEMS];

   assign req_ready = advance && !reset;
   assign csr_ready = !reset;
   assign accept    = req_valid && req_ready;

   assign slot = req_data.start_req ? '0 : item_count_ff;
   assign full = slot == LEN_BITS'(MAX_ITEMS);

   always_comb begin
      item_count_in = item_count_ff;
      if (accept) begin
         item_count_in = full ? slot : slot + LEN_BITS'(1);
      end
   end

   always_comb begin
      head_wave.start    = req_data.start_req;
      head_wave.full     = full;
      head_wave.count    = slot;
      head_wave.height   = req_data.height;
      head_wave.cand_len = '0;
      head_wave.cand_idx = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         min_gap_ff    <= '0;
      end else begin
         item_count_ff <= item_count_in;
         if (csr_valid) begin
            min_gap_ff <= csr_data;
         end
      end
   end

   assign stage_valid[0] = req_valid;
   assign stage_wave[0]  = head_wave;

   for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      lgs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_BITS'(gi)),
         .min_gap    (min_gap_ff),
         .up_valid   (stage_valid[gi]),
         .up_wave    (stage_wave[gi]),
         .dn_valid   (stage_valid[gi+1]),
         .dn_wave    (stage_wave[gi+1])
      );
   end

   lgs_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (stage_valid[MAX_ITEMS]),
      .up_wave   (stage_wave[MAX_ITEMS]),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/lgs_cell.sv -----
// ----------------------------------------------------------------------------
// lgs_cell: one storage cell of the chain
// Holds one stored element, checks the passing item against it, hands the
// updated candidate to the next cell and stores the item in its own slot.
// ----------------------------------------------------------------------------
module lgs_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [lgs_pkg::IDX_BITS-1:0] cell_index,
   input  logic [lgs_pkg::GAP_BITS-1:0] min_gap,
   input  logic                         up_valid,
   input  lgs_pkg::wave_type            up_wave,
   output logic                         dn_valid,
   output lgs_pkg::wave_type            dn_wave
);
   import lgs_pkg::*;

   logic [HEIGHT_BITS-1:0] height_ff;
   logic [LEN_BITS-1:0]    length_ff;
   logic                   dn_valid_ff;
   logic                   dn_valid_in;
   wave_type               dn_wave_ff;
   wave_type               dn_wave_in;

   logic [HEIGHT_BITS:0]   diff_up;
   logic [HEIGHT_BITS:0]   diff_dn;
   logic [HEIGHT_BITS-1:0] abs_diff;
   logic [LEN_BITS-1:0]    slot;
   logic                   occupied;
   logic                   gap_ok;
   logic                   hit;
   logic                   store;

   assign slot     = {{(LEN_BITS - IDX_BITS){1'b0}}, cell_index};
   assign diff_up  = {1'b0, up_wave.height} - {1'b0, height_ff};
   assign diff_dn  = {1'b0, height_ff} - {1'b0, up_wave.height};
   assign abs_diff = diff_up[HEIGHT_BITS] ? diff_dn[HEIGHT_BITS-1:0]
                                          : diff_up[HEIGHT_BITS-1:0];
   assign gap_ok   = CMP_BITS'(abs_diff) >= CMP_BITS'(min_gap);
   assign occupied = up_wave.count > slot;
   // Later cells win ties: the chain is scanned in index order.
   assign hit      = up_valid && occupied && gap_ok && (length_ff >= up_wave.cand_len);
   // By the time the item reaches its own slot, every stored cell is passed.
   assign store    = advance && up_valid && !up_wave.full && (up_wave.count == slot);

   always_comb begin
      dn_valid_in = up_valid;
      dn_wave_in  = up_wave;
      if (hit) begin
         dn_wave_in.cand_len = length_ff;
         dn_wave_in.cand_idx = slot + LEN_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else if (advance) begin
         dn_valid_ff <= dn_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dn_wave_ff <= dn_wave_in;
      end
      if (store) begin
         height_ff <= up_wave.height;
         length_ff <= up_wave.cand_len + LEN_BITS'(1);
      end
   end

   assign dn_valid = dn_valid_ff;
   assign dn_wave  = dn_wave_ff;

endmodule

// ----- rtl/lgs_tail.sv -----
// ----------------------------------------------------------------------------
// lgs_tail: end of the cell chain
// Finishes the chain length, tracks the best chain of the sequence and holds
// the result transaction in the output register.
// ----------------------------------------------------------------------------
module lgs_tail (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   input  lgs_pkg::wave_type up_wave,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lgs_pkg::rsp_type  rsp_data
);
   import lgs_pkg::*;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   logic [LEN_BITS-1:0] best_len_ff;
   logic [LEN_BITS-1:0] best_len_in;
   logic [LEN_BITS-1:0] best_idx_ff;
   logic [LEN_BITS-1:0] best_idx_in;
   logic [LEN_BITS-1:0] len;
   logic [LEN_BITS-1:0] base_len;
   logic [LEN_BITS-1:0] base_idx;

   assign advance  = !rsp_valid_ff || rsp_ready;
   assign len      = up_wave.cand_len + LEN_BITS'(1);
   assign base_len = up_wave.start ? '0 : best_len_ff;
   assign base_idx = up_wave.start ? '0 : best_idx_ff;

   always_comb begin
      best_len_in = best_len_ff;
      best_idx_in = best_idx_ff;
      if (up_valid) begin
         best_len_in = base_len;
         best_idx_in = base_idx;
         if (!up_wave.full && (len > base_len)) begin
            best_len_in = len;
            best_idx_in = up_wave.count + LEN_BITS'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in              = up_valid;
      rsp_data_in.chain_length  = len;
      rsp_data_in.predecessor   = up_wave.cand_idx;
      rsp_data_in.best_length   = best_len_in;
      rsp_data_in.best_end      = best_idx_in;
      rsp_data_in.full_res      = up_wave.full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         best_len_ff  <= '0;
         best_idx_ff  <= '0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
         best_len_ff  <= best_len_in;
         best_idx_ff  <= best_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/lgs_checker.sv -----
// ----------------------------------------------------------------------------
// lgs_checker: port-level checks
// Watches the ports of the top level for result transactions that break the
// relations between chain length, predecessor and best chain.
// ----------------------------------------------------------------------------
module lgs_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lgs_pkg::rsp_type rsp_data
);
   import lgs_pkg::*;

   // Hold a stalled result transaction.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_pred_len : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.predecessor == '0) == (rsp_data.chain_length == LEN_BITS'(1))))
      else $error("predecessor disagrees with chain length");

   a_best_cover : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.full_res |-> rsp_data.best_length >= rsp_data.chain_length)
      else $error("best length below stored chain length");

   a_best_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.full_res |-> rsp_data.best_end != '0)
      else $error("best end missing");

endmodule

bind longest_gapped_subsequence_top lgs_checker u_lgs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
